// ===== src/pngunf_pkg.sv =====
// shared types, constants and helper function of the png scanline unfilter
package pngunf_pkg;

  // default build limits
  localparam int unsigned DEF_MAX_WIDTH    = 8192;
  localparam int unsigned DEF_MAX_CHANNELS = 4;
  localparam int unsigned MAX_HEIGHT       = 8192;

  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ROW_IDX_W  = 13;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ALPHA  = 2'd2
  } cfg_idx_e;

  // row filter types
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  // one accepted byte on its way from control to reconstruction
  typedef struct packed {
    logic       is_err;    // bad filter byte, error beat
    logic [7:0] data;      // filtered sample
    logic [1:0] chan;      // channel of the byte within its pixel
    filt_e      filt;      // row filter
    logic       row_zero;  // first row of the image, nothing above
    logic       col0;      // first byte of the row
    logic       last;      // last byte of a pixel
    logic       eor;       // last pixel of the row
    logic       eoi;       // last pixel of the image
    logic       ch4;       // four channels
  } item_t;

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [9:0] s;
    logic [9:0] t;
    pa = (b > c) ? {2'b00, b - c} : {2'b00, c - b};
    pb = (a > c) ? {2'b00, a - c} : {2'b00, c - a};
    s  = {2'b00, a} + {2'b00, b};
    t  = {1'b0, c, 1'b0};
    pc = (s > t) ? (s - t) : (t - s);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

// ===== src/pngunf_in_if.sv =====
// input byte channel: valid, ready and one filtered byte
interface pngunf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_image;

  modport source (output valid, output data_byte, output start_image, input ready);
  modport sink   (input valid, input data_byte, input start_image, output ready);
endinterface

// ===== src/pngunf_out_if.sv =====
// output pixel channel: valid, ready and one rgba pixel with marks
interface pngunf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       end_of_row;
  logic       end_of_image;
  logic       status;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output end_of_row, output end_of_image, output status, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input end_of_row, input end_of_image, input status, output ready);
endinterface

// ===== src/pngunf_ram.sv =====
// prior row byte store, one write and one registered read port
module pngunf_ram #(
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

// ===== src/pngunf_ctrl.sv =====
// byte position tracking, filter byte decode and store read issue
module pngunf_ctrl import pngunf_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  pngunf_in_if.sink                                    in_i,
  input  logic [CFG_DATA_W-1:0]                        width_i,
  input  logic [CFG_DATA_W-1:0]                        height_i,
  input  logic                                         alpha_i,
  output logic                                         item_valid_o,
  output item_t                                        item_o,
  input  logic                                         item_ready_i,
  output logic                                         rd_en_o,
  output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0]    rd_addr_o
);
  localparam int unsigned Depth = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned ColW  = $clog2(Depth + 1);
  localparam int unsigned LenW  = ColW + 2;

  logic [ColW-1:0]      col_q, col_d;
  logic [1:0]           mod3_q, mod3_d;
  logic [ROW_IDX_W-1:0] row_q, row_d;
  logic                 at_start_q, at_start_d;
  logic                 err_q, err_d;
  filt_e                filt_q, filt_d;

  logic                  accept;
  logic                  ch4;
  logic [ColW-1:0]       w_eff;
  logic [LenW-1:0]       len_wide;
  logic [ColW-1:0]       row_len;
  logic [CFG_DATA_W-1:0] h_eff;
  logic [CFG_DATA_W-1:0] row_plus;
  logic                  last_row;
  logic [1:0]            chan;
  logic                  last_byte;
  logic [ColW-1:0]       col_next;
  logic                  row_end;
  logic                  err_eff;
  logic                  at_eff;
  logic                  sample;

  assign in_i.ready = item_ready_i;
  assign accept     = in_i.valid && item_ready_i;

  // clamp the geometry
  assign ch4 = alpha_i && (MAX_CHANNELS == 4);

  always_comb begin
    if (width_i == '0) begin
      w_eff = ColW'(1);
    end else if (32'(width_i) > MAX_WIDTH) begin
      w_eff = ColW'(MAX_WIDTH);
    end else begin
      w_eff = ColW'(width_i);
    end
    if (height_i == '0) begin
      h_eff = CFG_DATA_W'(1);
    end else if (32'(height_i) > MAX_HEIGHT) begin
      h_eff = CFG_DATA_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_i;
    end
  end

  assign len_wide = ch4 ? (LenW'(w_eff) << 2) : (LenW'(w_eff) + (LenW'(w_eff) << 1));
  assign row_len  = len_wide[ColW-1:0];

  assign row_plus  = CFG_DATA_W'(row_q) + CFG_DATA_W'(1);
  assign last_row  = row_plus >= h_eff;
  assign chan      = ch4 ? col_q[1:0] : mod3_q;
  assign last_byte = ch4 ? (chan == 2'd3) : (chan == 2'd2);
  assign col_next  = col_q + ColW'(1);
  assign row_end   = col_next >= row_len;

  assign err_eff = in_i.start_image ? 1'b0 : err_q;
  assign at_eff  = in_i.start_image ? 1'b1 : at_start_q;
  assign sample  = accept && !err_eff && !at_eff;

  // next state
  always_comb begin
    col_d      = col_q;
    mod3_d     = mod3_q;
    row_d      = row_q;
    at_start_d = at_start_q;
    err_d      = err_q;
    filt_d     = filt_q;
    if (accept) begin
      if (in_i.start_image) begin
        col_d      = '0;
        mod3_d     = '0;
        row_d      = '0;
        err_d      = 1'b0;
        at_start_d = 1'b1;
      end
      if (!err_eff) begin
        if (at_eff) begin
          if (in_i.data_byte > 8'(FILT_PAETH)) begin
            err_d = 1'b1;
          end else begin
            filt_d     = filt_e'(in_i.data_byte[2:0]);
            at_start_d = 1'b0;
            col_d      = '0;
            mod3_d     = '0;
          end
        end else if (row_end) begin
          at_start_d = 1'b1;
          col_d      = '0;
          mod3_d     = '0;
          row_d      = last_row ? '0 : row_plus[ROW_IDX_W-1:0];
        end else begin
          col_d  = col_next;
          mod3_d = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
        end
      end
    end
  end

  // item to reconstruction
  always_comb begin
    item_valid_o    = 1'b0;
    item_o          = '0;
    item_o.data     = in_i.data_byte;
    item_o.chan     = chan;
    item_o.filt     = filt_q;
    item_o.row_zero = (row_q == '0);
    item_o.col0     = (col_q == '0);
    item_o.last     = last_byte;
    item_o.eor      = last_byte && row_end;
    item_o.eoi      = last_byte && row_end && last_row;
    item_o.ch4      = ch4;
    if (accept && !err_eff && at_eff && in_i.data_byte > 8'(FILT_PAETH)) begin
      item_valid_o  = 1'b1;
      item_o.is_err = 1'b1;
    end else if (sample) begin
      item_valid_o = 1'b1;
    end
  end

  assign rd_en_o   = sample;
  assign rd_addr_o = col_q[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      mod3_q     <= '0;
      row_q      <= '0;
      at_start_q <= 1'b1;
      err_q      <= 1'b0;
      filt_q     <= FILT_NONE;
    end else begin
      col_q      <= col_d;
      mod3_q     <= mod3_d;
      row_q      <= row_d;
      at_start_q <= at_start_d;
      err_q      <= err_d;
      filt_q     <= filt_d;
    end
  end

  // a row start sits at column zero
  a_start_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    at_start_q |-> (col_q == '0 && mod3_q == 2'd0))
    else $error("row start away from column zero");

  // the error only latches on a filter byte
  a_err_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> at_start_q)
    else $error("error latched inside a row");

  // an item only leaves on an accepted byte
  a_item_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_o |-> (in_i.valid && item_ready_i))
    else $error("item without an accepted byte");
endmodule

// ===== src/pngunf_recon.sv =====
// byte reconstruction against the prior row store and pixel output register
module pngunf_recon import pngunf_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      item_valid_i,
  input  item_t                                     item_i,
  output logic                                      item_ready_o,
  input  logic                                      rd_en_i,
  input  logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] rd_addr_i,
  pngunf_out_if.source                              out_o
);
  localparam int unsigned Depth = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AddrW = $clog2(Depth);

  logic             s1_valid_q, s1_valid_d;
  item_t            s1_q;
  logic [AddrW-1:0] s1_addr_q;

  logic [31:0] left_q, left_d;
  logic [31:0] upper_q, upper_d;
  logic [23:0] asm_q, asm_d;

  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic       eor_q, eoi_q, status_q;

  logic [7:0]  rd_data;
  logic [31:0] left_eff, upper_eff;
  logic [23:0] asm_eff;
  logic [7:0]  a, b, c, pred, x;
  logic [8:0]  ab_sum;
  logic        has_res, out_free, s1_go, wr_en;

  pngunf_ram #(
    .DEPTH(Depth)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(x),
    .rd_en_i  (rd_en_i),
    .rd_addr_i(rd_addr_i),
    .rd_data_o(rd_data)
  );

  assign has_res      = s1_q.is_err || s1_q.last;
  assign out_free     = !out_valid_q || out_o.ready;
  assign s1_go        = s1_valid_q && (!has_res || out_free);
  assign item_ready_o = !s1_valid_q || s1_go;
  assign s1_valid_d   = item_ready_o ? item_valid_i : s1_valid_q;
  assign wr_en        = s1_go && !s1_q.is_err;

  // left and upper-left neighbors, first byte of a row sees zeros
  assign left_eff  = s1_q.col0 ? '0 : left_q;
  assign upper_eff = s1_q.col0 ? '0 : upper_q;
  assign asm_eff   = s1_q.col0 ? '0 : asm_q;
  assign a         = left_eff[8*s1_q.chan +: 8];
  assign c         = upper_eff[8*s1_q.chan +: 8];
  assign b         = s1_q.row_zero ? 8'h00 : rd_data;
  assign ab_sum    = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (s1_q.filt)
      FILT_NONE:  pred = 8'h00;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pred(a, b, c);
      default:    pred = 8'h00;
    endcase
  end

  assign x = s1_q.data + pred;

  // neighbor state update
  always_comb begin
    left_d  = left_q;
    upper_d = upper_q;
    asm_d   = asm_q;
    if (wr_en) begin
      upper_d                   = upper_eff;
      upper_d[8*s1_q.chan +: 8] = b;
      left_d                    = left_eff;
      asm_d                     = asm_eff;
      if (s1_q.last) begin
        left_d = s1_q.ch4 ? {x, asm_eff} : {8'h00, x, asm_eff[15:0]};
        asm_d  = '0;
      end else if (s1_q.chan != 2'd3) begin
        asm_d[8*s1_q.chan[1:0] +: 8] = x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_go && has_res) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      s1_q      <= item_i;
      s1_addr_q <= rd_addr_i;
    end
    left_q  <= left_d;
    upper_q <= upper_d;
    asm_q   <= asm_d;
    if (s1_go && has_res) begin
      if (s1_q.is_err) begin
        red_q    <= 8'h00;
        green_q  <= 8'h00;
        blue_q   <= 8'h00;
        alpha_q  <= 8'h00;
        eor_q    <= 1'b0;
        eoi_q    <= 1'b0;
        status_q <= 1'b1;
      end else begin
        red_q    <= asm_eff[7:0];
        green_q  <= asm_eff[15:8];
        blue_q   <= s1_q.ch4 ? asm_eff[23:16] : x;
        alpha_q  <= s1_q.ch4 ? x : ALPHA_OPAQUE;
        eor_q    <= s1_q.eor;
        eoi_q    <= s1_q.eoi;
        status_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.red          = red_q;
  assign out_o.green        = green_q;
  assign out_o.blue         = blue_q;
  assign out_o.alpha        = alpha_q;
  assign out_o.end_of_row   = eor_q;
  assign out_o.end_of_image = eoi_q;
  assign out_o.status       = status_q;

  // write back never lands on the entry being read in the same cycle
  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && wr_en) |-> (rd_addr_i != s1_addr_q))
    else $error("store read and write hit the same entry");

  // a stalled byte keeps its slot and its store data
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(s1_q) && $stable(rd_data)))
    else $error("stalled byte lost its contents");

  // a waiting pixel beat holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
      (out_o.valid &&
       $stable({red_q, green_q, blue_q, alpha_q, eor_q, eoi_q, status_q})))
    else $error("waiting pixel beat changed");
endmodule

// ===== src/png_scanline_unfilter_rgba.sv =====
// top level of the png scanline unfilter for 8-bit rgb and rgba
//
//  channel  dir  beat payload                                   handshake
//  in_i     in   data_byte[7:0], start_image                   valid/ready
//  out_o    out  red, green, blue, alpha, end_of_row,          valid/ready
//                end_of_image, status
//  cfg      in   cfg_idx_i[1:0], cfg_data_i[13:0]              cfg_we_i, no wait
//
// one byte per cycle unless a finished pixel waits on a stalled output; a pixel
// beat is built in reconstruction from the registered store read, then registered
// reset clears position, filter and error; the prior row store is not cleared
// and the first row of an image reads zeros above, so no fill pass is needed
// a stalled output holds one byte in the reconstruction stage; bytes that
// make no pixel keep flowing while a finished pixel waits
module png_scanline_unfilter_rgba import pngunf_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pngunf_in_if.sink             in_i,
  pngunf_out_if.source          out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int unsigned AddrW = $clog2(MAX_WIDTH * MAX_CHANNELS);

  // configuration registers
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic                  alpha_q;

  // control to reconstruction
  logic             item_valid;
  item_t            item;
  logic             item_ready;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DATA_W'(1);
      height_q <= CFG_DATA_W'(1);
      alpha_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_ALPHA:  alpha_q  <= cfg_data_i[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // position tracking and filter byte decode
  pngunf_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .alpha_i     (alpha_q),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_ready_i(item_ready),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr)
  );

  // reconstruction against the prior row, pixel output register
  pngunf_recon #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_ready_o(item_ready),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .out_o       (out_o)
  );
endmodule
